/* design/qsm3_pkg.sv */
package qsm3_pkg;

    localparam int unsigned DataWidth = 32;

    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic                        last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [DataWidth-1:0] sorted_value;
        logic                        last_result;
        logic                        overflow_flag;
    } t_out_item;

    // datapath operations requested by the controller
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_RD_A      = 4'd1,  // read store at the address
        OP_WR_A      = 4'd2,  // write register x at the address
        OP_WR_B      = 4'd3,  // write register y at the address
        OP_WR_P      = 4'd4,  // write pivot register at the address
        OP_WR_M0     = 4'd5,  // write median slot 0 at the address
        OP_LOAD      = 4'd6,  // write input value at the address
        OP_LATCH_X   = 4'd7,  // capture read data into x
        OP_LATCH_Y   = 4'd8,  // capture read data into y
        OP_LATCH_P   = 4'd9,  // capture read data into pivot
        OP_LATCH_M0  = 4'd10, // capture read data into median slot 0
        OP_LATCH_M1  = 4'd11,
        OP_LATCH_M2  = 4'd12
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [5:0] addr;
    } t_dp_cmd;

    typedef struct packed {
        logic ge_p_x;   // pivot >= x
        logic le_p_y;   // pivot <= y
        logic m0_gt_m1;
        logic m1_gt_m2;
        logic m0_gt_m2;
    } t_dp_stat;

endpackage

/* design/qsm3_ram.sv */
module qsm3_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/qsm3_datapath.sv */
module qsm3_datapath #(
    parameter int unsigned MAX_ITEMS  = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  qsm3_pkg::t_dp_cmd        i_cmd,
    input  logic [DATA_WIDTH-1:0]    i_value,
    output qsm3_pkg::t_dp_stat       o_stat,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    localparam int unsigned AW = $clog2(MAX_ITEMS);

    logic [DATA_WIDTH-1:0] rdata;
    logic [DATA_WIDTH-1:0] r_x, r_y, r_p, r_m0, r_m1, r_m2;
    logic                  we;
    logic [DATA_WIDTH-1:0] wdata;

    always_comb begin
        we    = 1'b0;
        wdata = i_value;
        case (i_cmd.op)
            qsm3_pkg::OP_WR_A: begin
                we    = 1'b1;
                wdata = r_x;
            end
            qsm3_pkg::OP_WR_B: begin
                we    = 1'b1;
                wdata = r_y;
            end
            qsm3_pkg::OP_WR_P: begin
                we    = 1'b1;
                wdata = r_p;
            end
            qsm3_pkg::OP_WR_M0: begin
                we    = 1'b1;
                wdata = r_m0;
            end
            qsm3_pkg::OP_LOAD: begin
                we = 1'b1;
            end
            default: ;
        endcase
    end

    qsm3_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(i_cmd.addr[AW-1:0]),
        .i_wdata(wdata),
        .i_raddr(i_cmd.addr[AW-1:0]),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            qsm3_pkg::OP_LATCH_X:  r_x  <= rdata;
            qsm3_pkg::OP_LATCH_Y:  r_y  <= rdata;
            qsm3_pkg::OP_LATCH_P:  r_p  <= rdata;
            qsm3_pkg::OP_LATCH_M0: r_m0 <= rdata;
            qsm3_pkg::OP_LATCH_M1: r_m1 <= rdata;
            qsm3_pkg::OP_LATCH_M2: r_m2 <= rdata;
            default: ;
        endcase
    end

    // signed compares
    assign o_stat.ge_p_x   = $signed(r_p) >= $signed(rdata);
    assign o_stat.le_p_y   = $signed(r_p) <= $signed(rdata);
    assign o_stat.m0_gt_m1 = $signed(r_m0) > $signed(r_m1);
    assign o_stat.m1_gt_m2 = $signed(r_m1) > $signed(r_m2);
    assign o_stat.m0_gt_m2 = $signed(r_m0) > $signed(r_m2);
    assign o_rdata         = rdata;

endmodule

/* design/qsm3_ctrl.sv */
module qsm3_ctrl #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_last_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_out_last,
    output logic               o_out_ovf,
    output logic               o_out_cap,
    output qsm3_pkg::t_dp_cmd  o_cmd,
    input  qsm3_pkg::t_dp_stat i_stat
);

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [21:0] {
        S_LOAD  = 22'h000001,
        S_POP   = 22'h000002,
        S_POPW  = 22'h000004,
        S_MR0   = 22'h000008,
        S_MR1   = 22'h000010,
        S_MR2   = 22'h000020,
        S_MR3   = 22'h000040,
        S_MSEL  = 22'h000080,
        S_PIV   = 22'h000100,
        S_XM    = 22'h000200,
        S_XP    = 22'h000400,
        S_SCL   = 22'h000800,
        S_SCLW  = 22'h001000,
        S_SCH   = 22'h002000,
        S_SCHW  = 22'h004000,
        S_DEC   = 22'h008000,
        S_XW2   = 22'h010000,
        S_FX2   = 22'h020000,
        S_PUSH  = 22'h040000,
        S_OREQ  = 22'h080000,
        S_OWAIT = 22'h100000,
        S_OSHOW = 22'h200000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic [AW-1:0]   r_lo, n_lo, r_hi, n_hi;
    logic [AW-1:0]   r_mid, n_mid;
    logic [AW-1:0]   r_b, n_b;         // median index
    logic [AW:0]     r_low, n_low;     // may reach hi+1
    logic [AW-1:0]   r_high, n_high;   // never below lo
    logic [AW:0]     r_sp, n_sp;
    logic [CW-1:0]   r_idx, n_idx;

    // range stack in a small ram, lo above hi in each word
    logic            stk_we;
    logic [AW-1:0]   stk_waddr, stk_raddr;
    logic [2*AW-1:0] stk_wdata, stk_rdata;

    logic [AW:0]     mid_sum;
    logic [AW-1:0]   med;
    logic            l_ok, r_ok, left_big;
    logic            a_ok, b_ok;
    logic [AW-1:0]   a_lo, a_hi, b_lo, b_hi;

    qsm3_ram #(.WIDTH(2 * AW), .DEPTH(MAX_ITEMS)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign stk_waddr = r_sp[AW-1:0];
    assign stk_raddr = r_sp[AW-1:0] - AW'(1);

    // subranges either side of the pivot at high
    assign l_ok     = {1'b0, r_high} > ({1'b0, r_lo} + (AW+1)'(1));
    assign r_ok     = ({1'b0, r_high} + (AW+1)'(1)) < {1'b0, r_hi};
    assign left_big = (r_high - r_lo) > (r_hi - r_high);

    // larger side goes on the stack, smaller side is sorted next
    always_comb begin
        if (left_big) begin
            a_ok = l_ok;
            a_lo = r_lo;
            a_hi = r_high - AW'(1);
            b_ok = r_ok;
            b_lo = r_high + AW'(1);
            b_hi = r_hi;
        end else begin
            a_ok = r_ok;
            a_lo = r_high + AW'(1);
            a_hi = r_hi;
            b_ok = l_ok;
            b_lo = r_lo;
            b_hi = r_high - AW'(1);
        end
    end

    // median index from the three comparisons
    always_comb begin
        if (i_stat.m0_gt_m1 == i_stat.m1_gt_m2) begin
            med = r_mid;
        end else if (i_stat.m0_gt_m1 == i_stat.m0_gt_m2) begin
            med = r_hi;
        end else begin
            med = r_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
            r_idx   <= n_idx;
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_b    <= n_b;
        r_low  <= n_low;
        r_high <= n_high;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_b         = r_b;
        n_low       = r_low;
        n_high      = r_high;
        n_sp        = r_sp;
        n_idx       = r_idx;
        stk_we      = 1'b0;
        stk_wdata   = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        o_out_ovf   = r_ovf;
        o_out_cap   = 1'b0;
        o_cmd.op    = qsm3_pkg::OP_NONE;
        o_cmd.addr  = '0;

        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.addr = 6'(r_cnt[AW-1:0]);
                if (i_in_valid) begin
                    if (r_cnt < CW'(MAX_ITEMS)) begin
                        o_cmd.op = qsm3_pkg::OP_LOAD;
                        n_cnt    = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_item) begin
                        n_sp  = '0;
                        n_idx = '0;
                        if (n_cnt > CW'(1)) begin
                            n_lo    = '0;
                            n_hi    = AW'(n_cnt - CW'(1));
                            n_state = S_MR0;
                        end else begin
                            n_state = S_OREQ;
                        end
                    end
                end
            end
            S_POP: begin
                // stack read issued here, word arrives next cycle
                if (r_sp == '0) begin
                    n_state = S_OREQ;
                end else begin
                    n_sp    = r_sp - (AW+1)'(1);
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_lo    = stk_rdata[2*AW-1:AW];
                n_hi    = stk_rdata[AW-1:0];
                n_state = S_MR0;
            end
            S_MR0: begin
                n_mid      = mid_sum[AW:1];
                o_cmd.op   = qsm3_pkg::OP_RD_A;
                o_cmd.addr = 6'(r_lo);
                n_state    = S_MR1;
            end
            S_MR1: begin
                o_cmd.op   = qsm3_pkg::OP_LATCH_M0;
                o_cmd.addr = 6'(r_mid);
                n_state    = S_MR2;
            end
            S_MR2: begin
                o_cmd.op   = qsm3_pkg::OP_LATCH_M1;
                o_cmd.addr = 6'(r_hi);
                n_state    = S_MR3;
            end
            S_MR3: begin
                o_cmd.op = qsm3_pkg::OP_LATCH_M2;
                n_state  = S_MSEL;
            end
            S_MSEL: begin
                n_b        = med;
                o_cmd.op   = qsm3_pkg::OP_RD_A;
                o_cmd.addr = 6'(med);
                n_state    = S_PIV;
            end
            S_PIV: begin
                o_cmd.op = qsm3_pkg::OP_LATCH_P;
                n_state  = S_XM;
            end
            S_XM: begin
                // old first element goes to the median slot
                o_cmd.op   = qsm3_pkg::OP_WR_M0;
                o_cmd.addr = 6'(r_b);
                n_state    = S_XP;
            end
            S_XP: begin
                // pivot goes to the first slot
                o_cmd.op   = qsm3_pkg::OP_WR_P;
                o_cmd.addr = 6'(r_lo);
                n_low      = {1'b0, r_lo} + (AW+1)'(1);
                n_high     = r_hi;
                n_state    = S_SCL;
            end
            S_SCL: begin
                // scan up: bound first, then read store[low]
                if (r_low <= {1'b0, r_hi}) begin
                    o_cmd.op   = qsm3_pkg::OP_RD_A;
                    o_cmd.addr = 6'(r_low[AW-1:0]);
                    n_state    = S_SCLW;
                end else begin
                    n_state = S_SCH;
                end
            end
            S_SCLW: begin
                o_cmd.op = qsm3_pkg::OP_LATCH_X;
                if (i_stat.ge_p_x) begin
                    n_low   = r_low + (AW+1)'(1);
                    n_state = S_SCL;
                end else begin
                    n_state = S_SCH;
                end
            end
            S_SCH: begin
                // scan down: bound first, then read store[high]
                if (r_high > r_lo) begin
                    o_cmd.op   = qsm3_pkg::OP_RD_A;
                    o_cmd.addr = 6'(r_high);
                    n_state    = S_SCHW;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_SCHW: begin
                o_cmd.op = qsm3_pkg::OP_LATCH_Y;
                if (i_stat.le_p_y) begin
                    n_high  = r_high - AW'(1);
                    n_state = S_SCH;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_low <= {1'b0, r_high}) begin
                    // exchange: x to high here, y to low next
                    o_cmd.op   = qsm3_pkg::OP_WR_A;
                    o_cmd.addr = 6'(r_high);
                    n_state    = S_XW2;
                end else if (r_high != r_lo) begin
                    // final exchange: pivot to high, y to lo next
                    o_cmd.op   = qsm3_pkg::OP_WR_P;
                    o_cmd.addr = 6'(r_high);
                    n_state    = S_FX2;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_XW2: begin
                o_cmd.op   = qsm3_pkg::OP_WR_B;
                o_cmd.addr = 6'(r_low[AW-1:0]);
                n_state    = S_SCL;
            end
            S_FX2: begin
                o_cmd.op   = qsm3_pkg::OP_WR_B;
                o_cmd.addr = 6'(r_lo);
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                // pivot sits at high
                if (b_ok) begin
                    if (a_ok && r_sp < (AW+1)'(MAX_ITEMS)) begin
                        stk_we    = 1'b1;
                        stk_wdata = {a_lo, a_hi};
                        n_sp      = r_sp + (AW+1)'(1);
                    end
                    n_lo    = b_lo;
                    n_hi    = b_hi;
                    n_state = S_MR0;
                end else if (a_ok) begin
                    n_lo    = a_lo;
                    n_hi    = a_hi;
                    n_state = S_MR0;
                end else begin
                    n_state = S_POP;
                end
            end
            S_OREQ: begin
                o_cmd.op   = qsm3_pkg::OP_RD_A;
                o_cmd.addr = 6'(r_idx[AW-1:0]);
                n_state    = S_OWAIT;
            end
            S_OWAIT: begin
                o_out_cap = 1'b1;
                n_state   = S_OSHOW;
            end
            S_OSHOW: begin
                o_out_valid = 1'b1;
                o_out_last  = (r_idx + CW'(1)) == r_cnt;
                if (i_out_ready) begin
                    if (o_out_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_sp    = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_OREQ;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

/* design/quicksort_median_of_three.sv */
// quicksort_median_of_three: collects signed values then sorts and emits them
//
// input channel: one value per transfer, last_item marks the end of a set;
// up to MAX_ITEMS values are kept, later ones are dropped and the run flagged
// a transfer is taken every cycle while loading, none while sorting or emitting
// after the last transfer the set is sorted in place with quicksort, pivot
// the median of first, middle and last; every store access goes through one
// single-port ram with a registered read, and pending ranges sit in a small ram
// each partition reads first, middle and last, moves the median pivot to
// the first slot, then scans up and down, exchanging out-of-order pairs,
// and finally swaps the pivot into its place
// output channel: one transfer per stored value, ascending, last_result on
// the final one and overflow_flag on all of a run that dropped input
// each result is read, captured and then shown; the result is held in an
// output register until the receiver takes it, and nothing moves meanwhile
// a set is never empty: the last transfer is kept unless the store is full
// reset returns to loading with an empty store; store contents are not cleared
module quicksort_median_of_three #(
    parameter int unsigned MAX_ITEMS  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  qsm3_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output qsm3_pkg::t_out_item  o_out_data
);

    qsm3_pkg::t_dp_cmd                cmd;
    qsm3_pkg::t_dp_stat               stat;
    logic [qsm3_pkg::DataWidth-1:0]   rdata;
    logic                             out_last, out_ovf, out_cap;
    logic [qsm3_pkg::DataWidth-1:0]   r_out_value;

    // controller: loading, partition sequencing, range stack, emit
    qsm3_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_last_item(i_in_data.last_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_last (out_last),
        .o_out_ovf  (out_ovf),
        .o_out_cap  (out_cap),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // datapath: element store, pivot and exchange registers, compares
    qsm3_datapath #(.MAX_ITEMS(MAX_ITEMS), .DATA_WIDTH(qsm3_pkg::DataWidth)) u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .i_value(i_in_data.value),
        .o_stat (stat),
        .o_rdata(rdata)
    );

    // output register holds the result through a stall
    always_ff @(posedge i_clk) begin
        if (out_cap) begin
            r_out_value <= rdata;
        end
    end

    assign o_out_data.sorted_value  = r_out_value;
    assign o_out_data.last_result   = out_last;
    assign o_out_data.overflow_flag = out_ovf;

endmodule
